### rtl/lspg_pkg.sv
// LED strip pattern generator: shared types, constants and helper functions.
// No dependencies; imported by every module of the block.
`default_nettype none

package lspg_pkg;

  // Strip geometry
  localparam int NUM_PIXELS = 16;
  localparam int PIX_W      = 5;

  // Timing constants (ms) and fixed levels
  localparam logic [31:0] PARTY_MS       = 32'd1600;
  localparam logic [31:0] PARTY_FRAME_MS = 32'd160;
  localparam logic [31:0] ANIM_FRAME_MS  = 32'd30;
  localparam logic [7:0]  PARTY_BRIGHT   = 8'd96;
  localparam logic [10:0] BREATH_PERIOD  = 11'd2000;
  localparam logic [9:0]  BREATH_HALF    = 10'd1000;

  // Reciprocals: floor((now>>4)/125) and floor(x/1000) for x < 2^18
  localparam logic [28:0] RECIP_125  = 29'd274877907;
  localparam logic [18:0] RECIP_1000 = 19'd268436;

  // Wheel segment bounds
  localparam logic [7:0] WHEEL_SEG1 = 8'd85;
  localparam logic [7:0] WHEEL_SEG2 = 8'd170;

  // Request codes
  typedef enum logic [2:0] {
    REQ_TICK  = 3'd0,
    REQ_PARTY = 3'd1,
    REQ_EN    = 3'd2,
    REQ_AUTO  = 3'd3,
    REQ_MODE  = 3'd4
  } req_code_e;

  typedef enum logic [1:0] {
    MODE_STATIC  = 2'd0,
    MODE_BREATH  = 2'd1,
    MODE_CHASE   = 2'd2,
    MODE_RAINBOW = 2'd3
  } mode_e;

  // Register indexes on the config port
  typedef enum logic [2:0] {
    REG_RED     = 3'd0,
    REG_GREEN   = 3'd1,
    REG_BLUE    = 3'd2,
    REG_BRIGHT  = 3'd3,
    REG_LUX_ON  = 3'd4,
    REG_LUX_OFF = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    FK_FILL,
    FK_BREATH,
    FK_CHASE,
    FK_RAINBOW
  } frame_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PREP,
    BK_STREAM
  } back_state_e;

  // Channel payloads
  typedef struct packed {
    logic [2:0]  req_type;
    logic [1:0]  arg_value;
    logic [31:0] now_ms;
    logic [23:0] lux_sample;
    logic        lux_present;
  } req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_index;
    logic [7:0]       pixel_red;
    logic [7:0]       pixel_green;
    logic [7:0]       pixel_blue;
    logic [7:0]       frame_brightness;
    logic             frame_last;
  } pix_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  bright;
    logic [23:0] lux_on;
    logic [23:0] lux_off;
  } cfg_t;

  // One frame to stream; bright holds user brightness for breathing frames
  typedef struct packed {
    frame_kind_e      kind;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       bright;
    logic [PIX_W-1:0] pos;
    logic [7:0]       hue;
    logic [31:0]      now_ms;
  } frame_t;

  // Queue entry: frames caused by one request
  typedef struct packed {
    logic   two;
    frame_t f0;
    frame_t f1;
  } cmd_t;

  typedef struct packed {
    logic             emit;
    frame_t           frame;
    logic [31:0]      lfm;
    logic [PIX_W-1:0] chase;
    logic [7:0]       hue;
  } rend_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef logic [7:0] base_tab_t [2**PIX_W];

  // Rainbow start hue of each pixel
  function automatic base_tab_t build_base();
    base_tab_t t;
    for (int i = 0; i < 2**PIX_W; i++) begin
      t[i] = (i < NUM_PIXELS) ? 8'((i * 256) / NUM_PIXELS) : 8'd0;
    end
    return t;
  endfunction

  localparam base_tab_t WHEEL_BASE = build_base();

  // Color wheel
  function automatic rgb_t wheel(input logic [7:0] p);
    logic [7:0] pos;
    logic [7:0] seg;
    logic [7:0] x3;
    rgb_t       c;
    pos = 8'd255 - p;
    if (pos < WHEEL_SEG1) begin
      seg = pos;
    end else if (pos < WHEEL_SEG2) begin
      seg = pos - WHEEL_SEG1;
    end else begin
      seg = pos - WHEEL_SEG2;
    end
    x3 = 8'({1'b0, seg} + {seg, 1'b0});
    if (pos < WHEEL_SEG1) begin
      c.r = 8'd255 - x3; c.g = 8'd0;          c.b = x3;
    end else if (pos < WHEEL_SEG2) begin
      c.r = 8'd0;          c.g = x3;          c.b = 8'd255 - x3;
    end else begin
      c.r = x3;            c.g = 8'd255 - x3; c.b = 8'd0;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/lspg_regs.sv
// LED strip pattern generator: APB configuration registers.
// Depends on lspg_pkg (cfg_t, reg_idx_e).
`default_nettype none

module lspg_regs
  import lspg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red     <= 8'd255;
      cfg_q.green   <= 8'd255;
      cfg_q.blue    <= 8'd255;
      cfg_q.bright  <= 8'd40;
      cfg_q.lux_on  <= 24'd160;
      cfg_q.lux_off <= 24'd480;
    end else if (wr_en) begin
      case (idx)
        REG_RED:     cfg_q.red     <= pwdata[7:0];
        REG_GREEN:   cfg_q.green   <= pwdata[7:0];
        REG_BLUE:    cfg_q.blue    <= pwdata[7:0];
        REG_BRIGHT:  cfg_q.bright  <= pwdata[7:0];
        REG_LUX_ON:  cfg_q.lux_on  <= pwdata[23:0];
        REG_LUX_OFF: cfg_q.lux_off <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_RED:     prdata = {24'd0, cfg_q.red};
      REG_GREEN:   prdata = {24'd0, cfg_q.green};
      REG_BLUE:    prdata = {24'd0, cfg_q.blue};
      REG_BRIGHT:  prdata = {24'd0, cfg_q.bright};
      REG_LUX_ON:  prdata = {8'd0, cfg_q.lux_on};
      REG_LUX_OFF: prdata = {8'd0, cfg_q.lux_off};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/lspg_front.sv
// LED strip pattern generator: request front end, flag/timer state, frame decisions.
// Depends on lspg_pkg; feeds frame commands to lspg_cmdq.
`default_nettype none

module lspg_front
  import lspg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  req_t      in_req_i,
  input  cfg_t      cfg_i,
  input  wire logic q_full_i,
  output logic      q_push_o,
  output cmd_t      q_cmd_o
);

  logic             on_q, on_d;
  logic             auto_q, auto_d;
  mode_e            mode_q, mode_d;
  logic [31:0]      lfm_q, lfm_d;
  logic [PIX_W-1:0] chase_q, chase_d;
  logic [7:0]       hue_q, hue_d;
  logic             party_q, party_d;
  logic [31:0]      pstart_q, pstart_d;
  logic [3:0]       saved_q, saved_d;

  logic [1:0]  nfr;
  frame_t      f0, f1, clr;
  rend_t       r;
  logic        flag;
  logic [31:0] now, elapsed;
  logic        accept;

  // Render one frame from the given flags, applying the frame pacing
  function automatic rend_t render(input logic on, input mode_e mode,
                                   input logic [31:0] lfm, input logic [PIX_W-1:0] chase,
                                   input logic [7:0] hue, input logic [31:0] t,
                                   input cfg_t c);
    rend_t o;
    logic  due;
    o.emit         = 1'b1;
    o.lfm          = lfm;
    o.chase        = chase;
    o.hue          = hue;
    o.frame.kind   = FK_FILL;
    o.frame.red    = c.red;
    o.frame.green  = c.green;
    o.frame.blue   = c.blue;
    o.frame.bright = c.bright;
    o.frame.pos    = chase;
    o.frame.hue    = hue;
    o.frame.now_ms = t;
    due = (lfm == 32'd0) || ((t - lfm) >= ANIM_FRAME_MS);
    if (!on) begin
      o.frame.red    = 8'd0;
      o.frame.green  = 8'd0;
      o.frame.blue   = 8'd0;
      o.frame.bright = 8'd0;
    end else if (mode != MODE_STATIC) begin
      o.emit = due;
      if (due) begin
        o.lfm = t;
      end
      case (mode)
        MODE_BREATH: o.frame.kind = FK_BREATH;
        MODE_CHASE: begin
          o.frame.kind = FK_CHASE;
          if (due) begin
            o.chase = ({1'b0, chase} == 6'(NUM_PIXELS - 1)) ? '0 : chase + 1'b1;
          end
          o.frame.pos = o.chase;
        end
        default: begin
          o.frame.kind = FK_RAINBOW;
          if (due) begin
            o.hue = hue + 8'd2;
          end
          o.frame.hue = o.hue;
        end
      endcase
    end
    return o;
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign now        = in_req_i.now_ms;
  assign flag       = (in_req_i.arg_value != 2'd0);
  assign elapsed    = now - pstart_q;

  // Request decode and state update
  always_comb begin
    on_d     = on_q;
    auto_d   = auto_q;
    mode_d   = mode_q;
    lfm_d    = lfm_q;
    chase_d  = chase_q;
    hue_d    = hue_q;
    party_d  = party_q;
    pstart_d = pstart_q;
    saved_d  = saved_q;
    nfr      = 2'd0;
    r        = render(1'b0, MODE_STATIC, lfm_q, chase_q, hue_q, now, cfg_i);
    clr      = r.frame;
    f0       = clr;
    f1       = clr;

    case (req_code_e'(in_req_i.req_type))
      REQ_TICK: begin
        if (party_q) begin
          if (elapsed >= PARTY_MS) begin
            // celebration over: restore flags and render
            party_d = 1'b0;
            on_d    = saved_q[0];
            auto_d  = saved_q[1];
            mode_d  = mode_e'(saved_q[3:2]);
            r = render(saved_q[0], mode_e'(saved_q[3:2]), 32'd0, '0, 8'd0, now, cfg_i);
            lfm_d   = r.lfm;
            chase_d = r.chase;
            hue_d   = r.hue;
            f0      = r.frame;
            nfr     = r.emit ? 2'd1 : 2'd0;
          end else if (lfm_q == 32'd0 || (now - lfm_q) >= PARTY_FRAME_MS) begin
            lfm_d     = now;
            f0.bright = PARTY_BRIGHT;
            f0.red    = 8'd0;
            // odd 160 ms slots
            if ((elapsed >= 32'd160  && elapsed < 32'd320)  ||
                (elapsed >= 32'd480  && elapsed < 32'd640)  ||
                (elapsed >= 32'd800  && elapsed < 32'd960)  ||
                (elapsed >= 32'd1120 && elapsed < 32'd1280) ||
                (elapsed >= 32'd1440)) begin
              f0.green = 8'd255;
              f0.blue  = 8'd90;
            end else begin
              f0.green = 8'd80;
              f0.blue  = 8'd255;
            end
            nfr = 2'd1;
          end
        end else begin
          // animation frame first
          if (on_q && mode_q != MODE_STATIC) begin
            r = render(on_q, mode_q, lfm_q, chase_q, hue_q, now, cfg_i);
            lfm_d   = r.lfm;
            chase_d = r.chase;
            hue_d   = r.hue;
            f0      = r.frame;
            nfr     = r.emit ? 2'd1 : 2'd0;
          end
          // lux hysteresis
          if (auto_q && in_req_i.lux_present) begin
            if (!on_q && in_req_i.lux_sample < cfg_i.lux_on) begin
              on_d = 1'b1;
              r = render(1'b1, mode_q, lfm_q, chase_q, hue_q, now, cfg_i);
              lfm_d   = r.lfm;
              chase_d = r.chase;
              hue_d   = r.hue;
              f0      = r.frame;
              nfr     = r.emit ? 2'd1 : 2'd0;
            end else if (on_q && in_req_i.lux_sample > cfg_i.lux_off) begin
              on_d = 1'b0;
              if (nfr == 2'd0) begin
                f0 = clr;
              end else begin
                f1 = clr;
              end
              nfr = nfr + 2'd1;
            end
          end
        end
      end
      REQ_PARTY: begin
        saved_d   = {mode_q, auto_q, on_q};
        party_d   = 1'b1;
        pstart_d  = now;
        lfm_d     = now;
        on_d      = 1'b1;
        auto_d    = 1'b0;
        mode_d    = MODE_STATIC;
        f0.red    = 8'd0;
        f0.green  = 8'd80;
        f0.blue   = 8'd255;
        f0.bright = PARTY_BRIGHT;
        nfr       = 2'd1;
      end
      REQ_EN: begin
        party_d = 1'b0;
        if (on_q != flag) begin
          on_d = flag;
          r = render(flag, mode_q, lfm_q, chase_q, hue_q, now, cfg_i);
          lfm_d   = r.lfm;
          chase_d = r.chase;
          hue_d   = r.hue;
          f0      = r.frame;
          nfr     = r.emit ? 2'd1 : 2'd0;
        end
      end
      REQ_AUTO: begin
        party_d = 1'b0;
        auto_d  = flag;
      end
      REQ_MODE: begin
        party_d = 1'b0;
        if (mode_q != mode_e'(in_req_i.arg_value)) begin
          mode_d = mode_e'(in_req_i.arg_value);
          r = render(on_q, mode_e'(in_req_i.arg_value), 32'd0, '0, 8'd0, now, cfg_i);
          lfm_d   = r.lfm;
          chase_d = r.chase;
          hue_d   = r.hue;
          f0      = r.frame;
          nfr     = r.emit ? 2'd1 : 2'd0;
        end
      end
      default: ;
    endcase
  end

  assign q_push_o   = accept && (nfr != 2'd0);
  assign q_cmd_o.two = (nfr == 2'd2);
  assign q_cmd_o.f0 = f0;
  assign q_cmd_o.f1 = f1;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q     <= 1'b0;
      auto_q   <= 1'b1;
      mode_q   <= MODE_STATIC;
      lfm_q    <= 32'd0;
      chase_q  <= '0;
      hue_q    <= 8'd0;
      party_q  <= 1'b0;
      pstart_q <= 32'd0;
      saved_q  <= 4'b0010;
    end else if (accept) begin
      on_q     <= on_d;
      auto_q   <= auto_d;
      mode_q   <= mode_d;
      lfm_q    <= lfm_d;
      chase_q  <= chase_d;
      hue_q    <= hue_d;
      party_q  <= party_d;
      pstart_q <= pstart_d;
      saved_q  <= saved_d;
    end
  end

endmodule

`default_nettype wire

### rtl/lspg_cmdq.sv
// LED strip pattern generator: two-entry frame command queue between front and back.
// Depends on lspg_pkg (cmd_t).
`default_nettype none

module lspg_cmdq
  import lspg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

### rtl/lspg_back.sv
// LED strip pattern generator: back end, breathing brightness unit and pixel streamer.
// Depends on lspg_pkg (frame_t, pix_t, wheel, WHEEL_BASE).
`default_nettype none

module lspg_back
  import lspg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pix_t      out_pix_o
);

  localparam logic [2:0] PREP_LAST = 3'd4;

  back_state_e      state_q, state_d;
  cmd_t             cur_q, cur_d;
  logic             sel_q, sel_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic [7:0]       bright_q, bright_d;
  logic [2:0]       cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;
  pix_t             out_q, out_d;

  // breathing pipeline
  logic [56:0] p1_q;
  logic [10:0] phase_q;
  logic [17:0] prod_q;
  logic [36:0] t_q;
  logic [21:0] quo;
  logic [9:0]  ramp;

  frame_t fr;
  logic   go, last_pix;
  rgb_t   wc;

  assign fr       = sel_q ? cur_q.f1 : cur_q.f0;
  assign go       = (state_q == BK_STREAM) && (!ovalid_q || out_ready_i);
  assign last_pix = (pix_q == PIX_W'(NUM_PIXELS - 1));
  assign quo      = p1_q[56:35];
  assign ramp     = (phase_q < {1'b0, BREATH_HALF}) ? phase_q[9:0]
                                                    : 10'(BREATH_PERIOD - phase_q);
  assign wc       = wheel(WHEEL_BASE[pix_q] + fr.hue);

  // Breathing brightness: now mod 2000, triangle, times brightness / 1000
  always_ff @(posedge clk_i) begin
    p1_q    <= 57'(fr.now_ms[31:4]) * 57'(RECIP_125);
    phase_q <= 11'(fr.now_ms - 32'(quo * 32'd2000));
    prod_q  <= 18'(ramp) * 18'(fr.bright);
    t_q     <= 37'(prod_q) * 37'(RECIP_1000);
  end

  // Sequencer and output register
  always_comb begin
    state_d  = state_q;
    cur_d    = cur_q;
    sel_d    = sel_q;
    pix_d    = pix_q;
    bright_d = bright_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q;
    out_d    = out_q;
    q_pop_o  = 1'b0;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o  = 1'b1;
          cur_d    = q_cmd_i;
          sel_d    = 1'b0;
          pix_d    = '0;
          cnt_d    = 3'd0;
          bright_d = q_cmd_i.f0.bright;
          state_d  = (q_cmd_i.f0.kind == FK_BREATH) ? BK_PREP : BK_STREAM;
        end
      end
      BK_PREP: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == PREP_LAST) begin
          bright_d = t_q[35:28];
          state_d  = BK_STREAM;
        end
      end
      BK_STREAM: begin
        if (go) begin
          ovalid_d               = 1'b1;
          out_d.pixel_index      = pix_q;
          out_d.frame_brightness = bright_q;
          out_d.frame_last       = last_pix;
          case (fr.kind)
            FK_CHASE: begin
              out_d.pixel_red   = (pix_q == fr.pos) ? fr.red : 8'd0;
              out_d.pixel_green = (pix_q == fr.pos) ? fr.green : 8'd0;
              out_d.pixel_blue  = (pix_q == fr.pos) ? fr.blue : 8'd0;
            end
            FK_RAINBOW: begin
              out_d.pixel_red   = wc.r;
              out_d.pixel_green = wc.g;
              out_d.pixel_blue  = wc.b;
            end
            default: begin
              out_d.pixel_red   = fr.red;
              out_d.pixel_green = fr.green;
              out_d.pixel_blue  = fr.blue;
            end
          endcase
          if (last_pix) begin
            pix_d = '0;
            if (!sel_q && cur_q.two) begin
              sel_d    = 1'b1;
              cnt_d    = 3'd0;
              bright_d = cur_q.f1.bright;
              state_d  = (cur_q.f1.kind == FK_BREATH) ? BK_PREP : BK_STREAM;
            end else begin
              state_d = BK_IDLE;
            end
          end else begin
            pix_d = pix_q + 1'b1;
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      sel_q    <= 1'b0;
      pix_q    <= '0;
      cnt_q    <= 3'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      sel_q    <= sel_d;
      pix_q    <= pix_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    bright_q <= bright_d;
    out_q    <= out_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_pix_o   = out_q;

  // Checks
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && out_q.frame_last |-> out_q.pixel_index == PIX_W'(NUM_PIXELS - 1))
    else $error("frame_last on wrong pixel");
  a_idle_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_IDLE |-> pix_q == '0)
    else $error("pixel counter not rewound");
  a_prep_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_PREP |-> cnt_q <= PREP_LAST)
    else $error("breathing prep overran");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == BK_PREP || state_q == BK_STREAM)
    else $error("popped command not started");

endmodule

`default_nettype wire

### rtl/led_strip_pattern_generator_core.sv
// LED strip pattern generator top level: config registers, front end, queue, back end.
// Depends on lspg_pkg, lspg_regs, lspg_front, lspg_cmdq, lspg_back.
//
//   channel | handshake              | beat
//   --------+------------------------+-------------------------------
//   in      | in_valid_i/in_ready_o  | req_t: one request
//   out     | out_valid_o/out_ready_i| pix_t: one pixel
//   config  | psel/penable/pwrite    | 32-bit data word, pready tied high
//
// The front stalls a request only when the two-entry queue is full.
// Each frame streams one pixel per cycle unless the output stalls; breathing frames
// first pass through the brightness pipeline; each command is popped in the idle state.
// A tick with an animation frame plus a clear frame queues both as one command.
// Reset is asynchronous; no clearing pass. Output stalls hold the pixel register.
`default_nettype none

module led_strip_pattern_generator_core
  import lspg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output pix_t             out_pix_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t cfg;
  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_cmd_in, q_cmd_out;

  lspg_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o (cfg)
  );

  lspg_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .cfg_i    (cfg),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (q_cmd_in)
  );

  lspg_cmdq u_cmdq (
    .clk_i, .rst_ni,
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out)
  );

  lspg_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd_out),
    .q_pop_o   (q_pop),
    .out_valid_o, .out_ready_i, .out_pix_o
  );

endmodule

`default_nettype wire

### test/led_strip_pattern_generator_core_tb.sv
// Testbench for led_strip_pattern_generator_core: directed table, then random requests.
// Depends on lspg_pkg and the core RTL; predicts every pixel and compares each beat.
`timescale 1ns / 100ps

module led_strip_pattern_generator_core_tb;
  import lspg_pkg::*;

  localparam logic [2:0] REQ_FIRST_BAD = 3'd5;
  localparam logic [2:0] REQ_BAD       = 3'd7;
  localparam int         IDLE_LIMIT    = 4000;
  localparam int         DRAIN_CYCLES  = 60;
  localparam int         HOLD_CYCLES   = 600;
  localparam int         RAND_PER_PH   = 24;

  typedef struct {
    logic [2:0]  req;
    logic [1:0]  arg;
    logic [31:0] now;
    logic [23:0] lux;
    logic        present;
    int          frames;  // -1: predictor only
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  req_t        in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  pix_t        out_pix_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  led_strip_pattern_generator_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_pix_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state
  cfg_t        cfg;
  logic        st_on, st_auto, st_party;
  mode_e       st_mode;
  logic [31:0] st_last_ms, st_party_t0;
  logic [4:0]  st_chase;
  logic [7:0]  st_hue;
  logic [3:0]  st_saved;
  pix_t        pixels_due[$];

  int  errors = 0;
  int  burst_left = 0;
  bit  hold_rx = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void queue_pixel(int idx, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, logic [7:0] br);
    pix_t p;
    p.pixel_index      = idx[4:0];
    p.pixel_red        = r;
    p.pixel_green      = g;
    p.pixel_blue       = b;
    p.frame_brightness = br;
    p.frame_last       = (idx == NUM_PIXELS - 1);
    pixels_due.push_back(p);
  endfunction

  function automatic void paint(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [7:0] br);
    for (int i = 0; i < NUM_PIXELS; i++) queue_pixel(i, r, g, b, br);
  endfunction

  function automatic bit frame_is_due(logic [31:0] now, logic [31:0] period);
    logic [31:0] dt;
    dt = now - st_last_ms;
    if (st_last_ms != 0 && dt < period) return 1'b0;
    st_last_ms = now;
    return 1'b1;
  endfunction

  // Color wheel, from the top of the ring down
  function automatic void hue_to_rgb(logic [7:0] h, output logic [7:0] r,
                                     output logic [7:0] g, output logic [7:0] b);
    int p;
    p = 255 - h;
    if (p < 85) begin
      r = 255 - 3 * p; g = 0; b = 3 * p;
    end else if (p < 170) begin
      p -= 85; r = 0; g = 3 * p; b = 255 - 3 * p;
    end else begin
      p -= 170; r = 3 * p; g = 255 - 3 * p; b = 0;
    end
  endfunction

  function automatic void draw(logic [31:0] now);
    int          ramp;
    logic [7:0]  r, g, b;
    if (!st_on) begin
      paint(0, 0, 0, 0);
      return;
    end
    case (st_mode)
      MODE_STATIC: paint(cfg.red, cfg.green, cfg.blue, cfg.bright);
      MODE_BREATH: begin
        if (!frame_is_due(now, ANIM_FRAME_MS)) return;
        ramp = now % 2000;
        if (ramp >= 1000) ramp = 2000 - ramp;
        paint(cfg.red, cfg.green, cfg.blue, 8'((ramp * cfg.bright) / 1000));
      end
      MODE_CHASE: begin
        if (!frame_is_due(now, ANIM_FRAME_MS)) return;
        st_chase = 5'((st_chase + 1) % NUM_PIXELS);
        for (int i = 0; i < NUM_PIXELS; i++) begin
          if (i == st_chase) queue_pixel(i, cfg.red, cfg.green, cfg.blue, cfg.bright);
          else queue_pixel(i, 0, 0, 0, cfg.bright);
        end
      end
      default: begin
        if (!frame_is_due(now, ANIM_FRAME_MS)) return;
        st_hue = st_hue + 8'd2;
        for (int i = 0; i < NUM_PIXELS; i++) begin
          hue_to_rgb(8'((i * 256) / NUM_PIXELS + st_hue), r, g, b);
          queue_pixel(i, r, g, b, cfg.bright);
        end
      end
    endcase
  endfunction

  function automatic void draw_party(logic [31:0] now);
    logic [31:0] elapsed;
    elapsed = now - st_party_t0;
    if (elapsed >= PARTY_MS) begin
      st_party   = 1'b0;
      st_on      = st_saved[0];
      st_auto    = st_saved[1];
      st_mode    = mode_e'(st_saved[3:2]);
      st_last_ms = '0;
      st_chase   = '0;
      st_hue     = '0;
      draw(now);
      return;
    end
    if (!frame_is_due(now, PARTY_FRAME_MS)) return;
    if (((elapsed / PARTY_FRAME_MS) % 2) == 0) paint(0, 80, 255, PARTY_BRIGHT);
    else paint(0, 255, 90, PARTY_BRIGHT);
  endfunction

  // Expected pixels for one accepted request; returns how many were added
  function automatic int predict_pixels(req_t q);
    int   n0;
    logic flag;
    n0   = pixels_due.size();
    flag = (q.arg_value != 0);
    case (q.req_type)
      REQ_TICK: begin
        if (st_party) draw_party(q.now_ms);
        else begin
          if (st_on && st_mode != MODE_STATIC) draw(q.now_ms);
          if (st_auto && q.lux_present) begin
            if (!st_on && q.lux_sample < cfg.lux_on) begin
              st_on = 1'b1; draw(q.now_ms);
            end else if (st_on && q.lux_sample > cfg.lux_off) begin
              st_on = 1'b0; draw(q.now_ms);
            end
          end
        end
      end
      REQ_PARTY: begin
        st_saved    = {st_mode, st_auto, st_on};
        st_party    = 1'b1;
        st_party_t0 = q.now_ms;
        st_last_ms  = '0;
        st_on       = 1'b1;
        st_auto     = 1'b0;
        st_mode     = MODE_STATIC;
        draw_party(q.now_ms);
      end
      REQ_EN: begin
        st_party = 1'b0;
        if (st_on != flag) begin
          st_on = flag; draw(q.now_ms);
        end
      end
      REQ_AUTO: begin
        st_party = 1'b0;
        st_auto  = flag;
      end
      REQ_MODE: begin
        st_party = 1'b0;
        if (st_mode != mode_e'(q.arg_value)) begin
          st_mode    = mode_e'(q.arg_value);
          st_last_ms = '0;
          st_chase   = '0;
          st_hue     = '0;
          draw(q.now_ms);
        end
      end
      default: ;
    endcase
    return pixels_due.size() - n0;
  endfunction

  // Register write: setup then access
  task automatic write_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_RED:    cfg.red     = val[7:0];
      REG_GREEN:  cfg.green   = val[7:0];
      REG_BLUE:   cfg.blue    = val[7:0];
      REG_BRIGHT: cfg.bright  = val[7:0];
      REG_LUX_ON: cfg.lux_on  = val[23:0];
      default:    cfg.lux_off = val[23:0];
    endcase
  endtask

  task automatic settle();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                            logic [31:0] br, logic [31:0] lon, logic [31:0] loff);
    settle();
    write_reg(REG_RED, r);
    write_reg(REG_GREEN, g);
    write_reg(REG_BLUE, b);
    write_reg(REG_BRIGHT, br);
    write_reg(REG_LUX_ON, lon);
    write_reg(REG_LUX_OFF, loff);
  endtask

  // One request beat; the sender goes quiet between bursts
  task automatic send_req(req_t q, int frames);
    int n;
    in_valid_i <= 1'b1;
    in_req_i   <= q;
    do @(posedge clk_i); while (!in_ready_o);
    n = predict_pixels(q);
    if (frames >= 0 && n != frames * NUM_PIXELS)
      report_mismatch($sformatf("req %0d at %0d: %0d pixels, table says %0d frames",
                                q.req_type, q.now_ms, n, frames));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
    end
  endtask

  // Directed requests; frame counts follow from the reset levels 160/480
  row_t rows[] = '{
    '{REQ_TICK,  2'd0, 32'd100,        24'd100,      1'b1,  1},
    '{REQ_TICK,  2'd0, 32'd200,        24'd1000,     1'b1,  1},
    '{REQ_EN,    2'd3, 32'd300,        24'd0,        1'b0,  1},
    '{REQ_EN,    2'd1, 32'd310,        24'd0,        1'b0,  0},
    '{REQ_MODE,  MODE_BREATH,  32'd0,  24'd0,        1'b0,  1},
    '{REQ_TICK,  2'd0, 32'd10,         24'd0,        1'b0,  1},
    '{REQ_TICK,  2'd0, 32'd20,         24'd0,        1'b0,  0},
    '{REQ_MODE,  MODE_CHASE,   32'd1000, 24'd0,      1'b0,  1},
    '{REQ_MODE,  MODE_CHASE,   32'd1010, 24'd0,      1'b0,  0},
    '{REQ_TICK,  2'd0, 32'd1040,       24'd0,        1'b0,  1},
    '{REQ_MODE,  MODE_RAINBOW, 32'd2000, 24'd0,      1'b0,  1},
    '{REQ_TICK,  2'd0, 32'd2031,       24'd0,        1'b0,  1},
    '{REQ_TICK,  2'd0, 32'hFFFF_FFFF,  24'd0,        1'b0,  1},
    '{REQ_AUTO,  2'd0, 32'd0,          24'd0,        1'b0,  0},
    '{REQ_AUTO,  2'd2, 32'd0,          24'd0,        1'b0,  0},
    '{REQ_PARTY, 2'd0, 32'd5000,       24'd0,        1'b0,  1},
    '{REQ_TICK,  2'd0, 32'd5100,       24'd0,        1'b1,  0},
    '{REQ_TICK,  2'd0, 32'd5170,       24'd0,        1'b1,  1},
    '{REQ_PARTY, 2'd0, 32'd5200,       24'd0,        1'b0,  1},
    '{REQ_TICK,  2'd0, 32'd6900,       24'd0,        1'b1,  1},
    '{REQ_PARTY, 2'd0, 32'd7000,       24'd0,        1'b0,  1},
    '{REQ_MODE,  MODE_BREATH,  32'd7050, 24'd0,      1'b0,  1},
    '{REQ_BAD,   2'd3, 32'd7060,       24'hFFFFFF,   1'b1,  0},
    '{REQ_EN,    2'd0, 32'd7100,       24'd0,        1'b0,  1},
    '{REQ_AUTO,  2'd1, 32'd7110,       24'd0,        1'b0,  0},
    '{REQ_TICK,  2'd0, 32'h8000_0000,  24'd0,        1'b1,  1},
    '{REQ_TICK,  2'd0, 32'h8000_0001,  24'hFFFFFF,   1'b1,  1}
  };

  // Stimulus
  initial begin
    req_t        q;
    logic [31:0] now;
    int          pick;
    cfg = '{8'd255, 8'd255, 8'd255, 8'd40, 24'd160, 24'd480};
    st_on = 1'b0; st_auto = 1'b1; st_mode = MODE_STATIC; st_last_ms = '0;
    st_chase = '0; st_hue = '0; st_party = 1'b0; st_party_t0 = '0; st_saved = 4'b0010;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_config(32'hFFFF_FFFF, 32'h0000_01FF, 32'd255, 32'd40, 32'd160, 32'hFF00_01E0);
    foreach (rows[i]) begin
      q = '{rows[i].req, rows[i].arg, rows[i].now, rows[i].lux, rows[i].present};
      send_req(q, rows[i].frames);
    end
    now = 32'd10000;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config(0, 0, 0, 0, 0, 0);
        1: set_config(32'hFF, 32'hFF, 32'hFF, 32'hFF, 32'hFFFFFF, 32'hFFFFFF);
        default: set_config($urandom, $urandom, $urandom, $urandom,
                            $urandom_range(0, 500), $urandom_range(0, 1000));
      endcase
      if (ph == 2) hold_rx = 1'b1;
      for (int n = 0; n < RAND_PER_PH; n++) begin
        now  = ($urandom_range(0, 19) == 0) ? $urandom : now + $urandom_range(0, 120);
        pick = $urandom_range(0, 99);
        q.req_type    = pick < 55 ? REQ_TICK : pick < 63 ? REQ_PARTY : pick < 75 ? REQ_EN :
                        pick < 83 ? REQ_AUTO : pick < 96 ? REQ_MODE :
                        3'($urandom_range(REQ_FIRST_BAD, REQ_BAD));
        q.arg_value   = $urandom_range(0, 3);
        q.now_ms      = now;
        q.lux_sample  = $urandom_range(0, 1) ? 24'($urandom_range(0, 700)) : 24'($urandom);
        q.lux_present = $urandom_range(0, 7) != 0;
        send_req(q, -1);
      end
    end
    settle();
    if (errors == 0) $display("[led_strip_pattern_generator_core] OK");
    else $display("[led_strip_pattern_generator_core] ERROR");
    $finish;
  end

  // Receiver: duty pattern that changes now and then, plus one long hold
  initial begin
    int period, duty;
    forever begin
      if (hold_rx) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end else begin
        period = $urandom_range(1, 7);
        duty   = $urandom_range(0, 2) == 0 ? period : $urandom_range(1, period);
        for (int c = 0; c < 150; c++) begin
          out_ready_i <= (c % period) < duty;
          @(posedge clk_i);
        end
      end
    end
  end

  // Pixel check and idle watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    pix_t e;
    if (out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        report_mismatch("pixel beat with nothing expected");
      end else begin
        e = pixels_due.pop_front();
        if (out_pix_o.pixel_index != e.pixel_index)
          report_mismatch($sformatf("pixel_index %0d, want %0d",
                                    out_pix_o.pixel_index, e.pixel_index));
        if (out_pix_o.pixel_red != e.pixel_red)
          report_mismatch($sformatf("pixel %0d red %0d, want %0d", e.pixel_index,
                                    out_pix_o.pixel_red, e.pixel_red));
        if (out_pix_o.pixel_green != e.pixel_green)
          report_mismatch($sformatf("pixel %0d green %0d, want %0d", e.pixel_index,
                                    out_pix_o.pixel_green, e.pixel_green));
        if (out_pix_o.pixel_blue != e.pixel_blue)
          report_mismatch($sformatf("pixel %0d blue %0d, want %0d", e.pixel_index,
                                    out_pix_o.pixel_blue, e.pixel_blue));
        if (out_pix_o.frame_brightness != e.frame_brightness)
          report_mismatch($sformatf("pixel %0d brightness %0d, want %0d", e.pixel_index,
                                    out_pix_o.frame_brightness, e.frame_brightness));
        if (out_pix_o.frame_last != e.frame_last)
          report_mismatch($sformatf("pixel %0d frame_last %0b, want %0b", e.pixel_index,
                                    out_pix_o.frame_last, e.frame_last));
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[led_strip_pattern_generator_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
